// ===== design/random_access_request_controller_macros.svh =====
// ----------------------------------------------------------------------------
// Random-access request controller assertion macros
// Shared assertion forms for the controller RTL. They expect clk and arst_n
// to be visible in the module that expands them.
// ----------------------------------------------------------------------------
`ifndef RANDOM_ACCESS_REQUEST_CONTROLLER_MACROS_SVH
`define RANDOM_ACCESS_REQUEST_CONTROLLER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RACC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define RACC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/racc_pkg.sv =====
// ----------------------------------------------------------------------------
// Random-access request controller package
// Widths, item kinds, register indexes and reset values shared by the design.
// ----------------------------------------------------------------------------
package racc_pkg;

	localparam int unsigned KIND_W     = 3;
	localparam int unsigned PREAMBLE_W = 6;
	localparam int unsigned BACKOFF_W  = 16;
	localparam int unsigned BYTES_W    = 24;
	localparam int unsigned RESP_W     = 8;
	localparam int unsigned RETX_W     = 10;
	localparam int unsigned TRIES_W    = 8;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 10;

	typedef logic [KIND_W-1:0]     kind_t;
	typedef logic [PREAMBLE_W-1:0] preamble_t;
	typedef logic [BACKOFF_W-1:0]  backoff_t;
	typedef logic [BYTES_W-1:0]    bytes_t;
	typedef logic [RESP_W-1:0]     resp_t;
	typedef logic [RETX_W-1:0]     retx_t;
	typedef logic [TRIES_W-1:0]    tries_t;
	typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
	typedef logic [CFG_DATA_W-1:0] cfg_data_t;

	// Item kinds carried in req_type. Codes 5 to 7 carry no meaning.
	localparam kind_t KIND_TICK       = 3'd0;
	localparam kind_t KIND_RAC_RSP    = 3'd1;
	localparam kind_t KIND_SL_GRANT   = 3'd2;
	localparam kind_t KIND_SL_BSR     = 3'd3;
	localparam kind_t KIND_UU_BSR_DONE = 3'd4;

	// Configuration register indexes.
	localparam cfg_idx_t CFG_MAX_TRIES   = 3'd0;
	localparam cfg_idx_t CFG_RESP_WINDOW = 3'd1;
	localparam cfg_idx_t CFG_BSR_RETX    = 3'd2;
	localparam cfg_idx_t CFG_SL_PRESENT  = 3'd3;

	localparam tries_t RST_MAX_TRIES   = 8'd3;
	localparam resp_t  RST_RESP_WINDOW = 8'd3;
	localparam retx_t  RST_BSR_RETX    = 10'd40;
	localparam logic   RST_SL_PRESENT  = 1'b1;

endpackage

// ===== design/racc_if.sv =====
// ----------------------------------------------------------------------------
// Random-access request controller channels
// Valid/ready interfaces for the request, result and configuration channels.
// ----------------------------------------------------------------------------
interface racc_req_if;
	import racc_pkg::*;

	logic      valid;
	logic      ready;
	kind_t     req_type;
	logic      uu_backlog;
	logic      sl_backlog;
	preamble_t preamble_draw;
	logic      rac_success;
	backoff_t  backoff_draw;
	bytes_t    sl_bsr_bytes;
	logic      harq_available;

	modport source (
		output valid, req_type, uu_backlog, sl_backlog, preamble_draw,
		       rac_success, backoff_draw, sl_bsr_bytes, harq_available,
		input  ready
	);
	modport sink (
		input  valid, req_type, uu_backlog, sl_backlog, preamble_draw,
		       rac_success, backoff_draw, sl_bsr_bytes, harq_available,
		output ready
	);
endinterface

interface racc_rsp_if;
	import racc_pkg::*;

	logic      valid;
	logic      ready;
	logic      rac_sent;
	logic      sl_triggered;
	preamble_t preamble_out;
	logic      uu_bsr_armed;
	logic      sl_bsr_armed;
	logic      bsr_pdu_queued;
	logic      rac_gave_up;
	logic      grant_error;

	modport source (
		output valid, rac_sent, sl_triggered, preamble_out, uu_bsr_armed,
		       sl_bsr_armed, bsr_pdu_queued, rac_gave_up, grant_error,
		input  ready
	);
	modport sink (
		input  valid, rac_sent, sl_triggered, preamble_out, uu_bsr_armed,
		       sl_bsr_armed, bsr_pdu_queued, rac_gave_up, grant_error,
		output ready
	);
endinterface

interface racc_cfg_if;
	import racc_pkg::*;

	logic      valid;
	logic      ready;
	cfg_idx_t  reg_index;
	cfg_data_t write_data;

	modport source (output valid, reg_index, write_data, input ready);
	modport sink   (input valid, reg_index, write_data, output ready);
endinterface

// ===== design/random_access_request_controller.sv =====
// ----------------------------------------------------------------------------
// Random-access request controller
// UE-side random access and BSR trigger control with an attached sidelink side.
// ----------------------------------------------------------------------------
// Usage:
// Items arrive on the req channel, one per beat: ticks, RAC responses,
// sidelink grants, sidelink BSR sends and Uu BSR consumed events. Every item
// yields exactly one result beat on the rsp channel, in order.
// The cfg channel writes the four configuration registers; it is always
// ready and a write to an index past the last register is dropped. Writes are
// meant to happen only while no item is in flight.
// Each result is registered: an item taken at one edge has its result valid right
// after that edge. Throughput is one item per cycle; the only limit is the
// single result register, which a new item refills in the same cycle that
// the receiver takes the old result.
// When the receiver stalls, the result register holds and req.ready drops
// until the result is taken, so no item is lost and state does not advance.
// Reset clears all timers, counters, guards and trigger flags, empties the
// result register and loads the configuration defaults (3, 3, 40, 1).
// ----------------------------------------------------------------------------
`include "random_access_request_controller_macros.svh"

module random_access_request_controller (
	input  logic       clk,
	input  logic       arst_n,
	racc_req_if.sink   req,
	racc_rsp_if.source rsp,
	racc_cfg_if.sink   cfg
);
	import racc_pkg::*;

	// Configuration registers.
	tries_t max_tries_q;
	resp_t  resp_window_q;
	retx_t  bsr_retx_start_q;
	logic   sl_present_q;

	// Controller state.
	backoff_t backoff_q;
	resp_t    resp_timer_q;
	retx_t    retx_timer_q;
	tries_t   try_count_q;
	logic     uu_req_q;
	logic     sl_req_q;
	logic     uu_flag_q;
	logic     sl_flag_q;

	// Result register.
	logic      out_valid_q;
	logic      sent_q;
	logic      sl_trig_q;
	preamble_t preamble_q;
	logic      uu_armed_q;
	logic      sl_armed_q;
	logic      queued_q;
	logic      gave_up_q;
	logic      gerr_q;

	// Next-state and result values for the item at the input.
	backoff_t backoff_d;
	resp_t    resp_timer_d;
	retx_t    retx_timer_d;
	tries_t   try_count_d;
	logic     uu_req_d;
	logic     sl_req_d;
	logic     uu_flag_d;
	logic     sl_flag_d;
	logic     sent_d;
	logic     sl_trig_d;
	preamble_t preamble_d;
	logic     queued_d;
	logic     gave_up_d;
	logic     gerr_d;

	logic              in_fire;
	logic              sl_start;
	logic [TRIES_W:0]  next_try;

	// The result register frees up whenever it is empty or being taken.
	assign req.ready = !out_valid_q || rsp.ready;
	assign in_fire   = req.valid && req.ready;
	assign cfg.ready = 1'b1;

	// A sidelink request needs a sidelink backlog, no Uu backlog and an attached sidelink side.
	assign sl_start = !req.uu_backlog && sl_present_q && req.sl_backlog;
	// The failure count is compared one bit wider so it never wraps.
	assign next_try = {1'b0, try_count_q} + {{TRIES_W{1'b0}}, 1'b1};

	always_comb begin
		backoff_d    = backoff_q;
		resp_timer_d = resp_timer_q;
		retx_timer_d = retx_timer_q;
		try_count_d  = try_count_q;
		uu_req_d     = uu_req_q;
		sl_req_d     = sl_req_q;
		uu_flag_d    = uu_flag_q;
		sl_flag_d    = sl_flag_q;
		sent_d       = 1'b0;
		sl_trig_d    = 1'b0;
		preamble_d   = '0;
		queued_d     = 1'b0;
		gave_up_d    = 1'b0;
		gerr_d       = 1'b0;
		unique case (req.req_type)
			KIND_TICK: begin
				// Timers count down one at a time in priority order; only
				// when all are idle do the guards clear or a request go out.
				priority if (backoff_q != '0) begin
					backoff_d = backoff_q - 1'b1;
				end else if (resp_timer_q != '0) begin
					resp_timer_d = resp_timer_q - 1'b1;
				end else if (retx_timer_q != '0) begin
					retx_timer_d = retx_timer_q - 1'b1;
				end else if (uu_req_q) begin
					uu_req_d = 1'b0;
				end else if (sl_req_q) begin
					sl_req_d = 1'b0;
				end else begin
					uu_req_d = req.uu_backlog;
					sl_req_d = sl_start;
					if (req.uu_backlog || sl_start) begin
						sent_d       = 1'b1;
						sl_trig_d    = sl_start;
						preamble_d   = req.preamble_draw;
						resp_timer_d = resp_window_q;
					end
				end
			end
			KIND_RAC_RSP: begin
				if (req.rac_success) begin
					// Success arms the BSR of whichever side asked.
					if (sl_req_q) begin
						sl_flag_d = 1'b1;
						sl_req_d  = 1'b0;
					end else begin
						uu_flag_d = 1'b1;
					end
					try_count_d = '0;
					backoff_d   = '0;
				end else if (next_try >= {1'b0, max_tries_q}) begin
					try_count_d = '0;
					backoff_d   = '0;
					sl_req_d    = 1'b0;
					gave_up_d   = 1'b1;
				end else begin
					try_count_d = next_try[TRIES_W-1:0];
					backoff_d   = req.backoff_draw;
				end
			end
			KIND_SL_GRANT: begin
				if (!sl_present_q) begin
					gerr_d = 1'b1;
				end else begin
					uu_req_d     = 1'b0;
					retx_timer_d = '0;
				end
			end
			KIND_SL_BSR: begin
				sl_flag_d = 1'b0;
				// Without a sidelink side the backlog counts as empty.
				if (!sl_present_q || req.sl_bsr_bytes == '0) begin
					retx_timer_d = '0;
				end else begin
					retx_timer_d = bsr_retx_start_q;
					queued_d     = req.harq_available;
				end
			end
			KIND_UU_BSR_DONE: begin
				uu_flag_d = 1'b0;
			end
			default: begin
			end
		endcase
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_tries_q      <= RST_MAX_TRIES;
			resp_window_q    <= RST_RESP_WINDOW;
			bsr_retx_start_q <= RST_BSR_RETX;
			sl_present_q     <= RST_SL_PRESENT;
		end else if (cfg.valid) begin
			unique case (cfg.reg_index)
				CFG_MAX_TRIES:   max_tries_q      <= cfg.write_data[TRIES_W-1:0];
				CFG_RESP_WINDOW: resp_window_q    <= cfg.write_data[RESP_W-1:0];
				CFG_BSR_RETX:    bsr_retx_start_q <= cfg.write_data[RETX_W-1:0];
				CFG_SL_PRESENT:  sl_present_q     <= cfg.write_data[0];
				default: begin
				end
			endcase
		end
	end

	// Controller state advances only on an accepted item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			backoff_q    <= '0;
			resp_timer_q <= '0;
			retx_timer_q <= '0;
			try_count_q  <= '0;
			uu_req_q     <= 1'b0;
			sl_req_q     <= 1'b0;
			uu_flag_q    <= 1'b0;
			sl_flag_q    <= 1'b0;
		end else if (in_fire) begin
			backoff_q    <= backoff_d;
			resp_timer_q <= resp_timer_d;
			retx_timer_q <= retx_timer_d;
			try_count_q  <= try_count_d;
			uu_req_q     <= uu_req_d;
			sl_req_q     <= sl_req_d;
			uu_flag_q    <= uu_flag_d;
			sl_flag_q    <= sl_flag_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload carries no reset; it is only looked at under valid.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			sent_q     <= sent_d;
			sl_trig_q  <= sl_trig_d;
			preamble_q <= preamble_d;
			uu_armed_q <= uu_flag_d;
			sl_armed_q <= sl_flag_d;
			queued_q   <= queued_d;
			gave_up_q  <= gave_up_d;
			gerr_q     <= gerr_d;
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.rac_sent       = sent_q;
	assign rsp.sl_triggered   = sl_trig_q;
	assign rsp.preamble_out   = preamble_q;
	assign rsp.uu_bsr_armed   = uu_armed_q;
	assign rsp.sl_bsr_armed   = sl_armed_q;
	assign rsp.bsr_pdu_queued = queued_q;
	assign rsp.rac_gave_up    = gave_up_q;
	assign rsp.grant_error    = gerr_q;

	// A tick under a running backoff only counts it down and sends nothing.
	`RACC_ASSERT_NEXT(a_backoff_blocks, in_fire && req.req_type == KIND_TICK && backoff_q != '0, !sent_q && backoff_q == $past(backoff_q) - 1'b1, "tick under backoff misbehaved")
	// A sent request always opens the configured response window.
	`RACC_ASSERT_NEXT(a_window_loaded, in_fire && sent_d, resp_timer_q == $past(resp_window_q), "response window not loaded")
	// A reported give-up leaves the retry state cleared.
	`RACC_ASSERT_NOW(a_gave_up_clear, out_valid_q && gave_up_q, try_count_q == '0 && backoff_q == '0, "give-up left retry state")
	// A sidelink-triggered result is always a sent request.
	`RACC_ASSERT_NOW(a_sl_trig_sent, out_valid_q && sl_trig_q, sent_q && !gerr_q, "sidelink trigger without request")

endmodule
